/* rtl/int_matrix_vector_multiply_defines.svh */
// Assertion macros shared by the matrix-vector multiply RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef INT_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define INT_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define IMVM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IMVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define IMVM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define IMVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/imvm_pkg.sv */
package imvm_pkg;

   localparam int IDX_W   = 6;
   localparam int DATA_W  = 32;
   localparam int CFG_W   = 5;
   localparam int CMP_W   = IDX_W + 1;

   localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] OP_LOAD_VECTOR = 2'd1;
   localparam logic [1:0] OP_MULTIPLY    = 2'd2;

   localparam logic REG_NUM_ROWS = 1'b0;
   localparam logic REG_NUM_COLS = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_OUT_RANGE = 1'b1;

   typedef struct packed {
      logic [1:0]              operation;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [DATA_W-1:0] value;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [IDX_W-1:0]        result_row;
      logic                    last;
      logic                    status;
   } rsp_data_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              mat_we;
      logic              vec_we;
      logic              err;
      logic              rd_en;
      logic              rd_first;
      logic              rd_last;
      logic              rd_last_row;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] wr_value;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
      logic row_done;
   } status_type;

endpackage

/* rtl/imvm_ram.sv */
module imvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/imvm_ctrl.sv */
`include "int_matrix_vector_multiply_defines.svh"

module imvm_ctrl #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  imvm_pkg::req_data_type  req_data,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [imvm_pkg::CFG_W-1:0] csr_wdata,
   output imvm_pkg::cmd_type       cmd,
   input  imvm_pkg::status_type    status
);

   import imvm_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
   localparam int COL_W  = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [RCNT_W-1:0] rows_ff, rows_in;
   logic [CCNT_W-1:0] cols_ff, cols_in;
   logic              accept;
   logic              row_ok;
   logic              col_ok;
   logic              col_last;
   logic              row_last;

   // A written size of zero counts as one; sizes above the maximum saturate.
   function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] x);
      if (x == '0) begin
         return RCNT_W'(1);
      end
      if (CMP_W'(x) > CMP_W'(MAX_ROWS)) begin
         return RCNT_W'(MAX_ROWS);
      end
      return RCNT_W'(x);
   endfunction

   function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] x);
      if (x == '0) begin
         return CCNT_W'(1);
      end
      if (CMP_W'(x) > CMP_W'(MAX_COLS)) begin
         return CCNT_W'(MAX_COLS);
      end
      return CCNT_W'(x);
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || status.busy;
   assign accept    = req_valid && !req_stall;

   assign row_ok   = CMP_W'(req_data.row_index) < CMP_W'(rows_ff);
   assign col_ok   = CMP_W'(req_data.col_index) < CMP_W'(cols_ff);
   assign col_last = CCNT_W'(col_ff) == (cols_ff - CCNT_W'(1));
   assign row_last = RCNT_W'(row_ff) == (rows_ff - RCNT_W'(1));

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      cmd      = '0;

      if (csr_we) begin
         case (csr_index)
            REG_NUM_ROWS: rows_in = clamp_rows(csr_wdata);
            REG_NUM_COLS: cols_in = clamp_cols(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            cmd.row      = req_data.row_index;
            cmd.col      = req_data.col_index;
            cmd.wr_value = req_data.value;
            if (accept) begin
               case (req_data.operation)
                  OP_LOAD_MATRIX: begin
                     cmd.mat_we = row_ok && col_ok;
                     cmd.err    = !(row_ok && col_ok);
                  end
                  OP_LOAD_VECTOR: begin
                     cmd.vec_we = col_ok;
                     cmd.err    = !col_ok;
                  end
                  OP_MULTIPLY: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.row = IDX_W'(row_ff);
            cmd.col = IDX_W'(col_ff);
            // A row starts only when the output register can take its result.
            if (!(col_ff == '0 && status.busy)) begin
               cmd.rd_en       = 1'b1;
               cmd.rd_first    = col_ff == '0;
               cmd.rd_last     = col_last;
               cmd.rd_last_row = row_last;
               if (col_last) begin
                  state_in = ST_WAIT;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         ST_WAIT: begin
            if (status.row_done) begin
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  col_in   = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         rows_ff  <= RCNT_W'(1);
         cols_ff  <= CCNT_W'(1);
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
      end
   end

   `IMVM_ASSERT_IMPL(a_done_in_wait, clock, reset, status.row_done, state_ff == ST_WAIT, "row result arrived outside the wait state")
   `IMVM_ASSERT_IMPL(a_one_command, clock, reset, 1'b1, $onehot0({cmd.mat_we, cmd.vec_we, cmd.err, cmd.rd_en}), "more than one datapath command at once")
   `IMVM_ASSERT_NEXT(a_issue_after_wait, clock, reset, state_ff == ST_WAIT && status.row_done && !row_last, state_ff == ST_ISSUE && col_ff == '0, "next row did not restart at the first column")

endmodule

/* rtl/imvm_datapath.sv */
`include "int_matrix_vector_multiply_defines.svh"

module imvm_datapath #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  imvm_pkg::cmd_type       cmd,
   output imvm_pkg::status_type    status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output imvm_pkg::rsp_data_type  rsp_data
);

   import imvm_pkg::*;

   localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MAT_AW    = $clog2(MAT_DEPTH > 1 ? MAT_DEPTH : 2);
   localparam int VEC_AW    = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);

   logic [MAT_AW-1:0] mat_addr;
   logic [VEC_AW-1:0] vec_addr;
   logic [DATA_W-1:0] mat_rdata;
   logic [DATA_W-1:0] vec_rdata;

   logic              s1_valid_ff, s1_first_ff, s1_last_ff, s1_last_row_ff;
   logic [IDX_W-1:0]  s1_row_ff;
   logic              s2_valid_ff, s2_first_ff, s2_last_ff, s2_last_row_ff;
   logic [IDX_W-1:0]  s2_row_ff;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;
   logic              row_done;

   // The matrix keeps a fixed row stride of MAX_COLS entries.
   assign mat_addr = MAT_AW'(int'(cmd.row) * MAX_COLS + int'(cmd.col));
   assign vec_addr = VEC_AW'(cmd.col);

   imvm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAT_DEPTH)
   ) u_mat_ram (
      .clock (clock),
      .we    (cmd.mat_we),
      .waddr (mat_addr),
      .wdata (cmd.wr_value),
      .raddr (mat_addr),
      .rdata (mat_rdata)
   );

   imvm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_COLS)
   ) u_vec_ram (
      .clock (clock),
      .we    (cmd.vec_we),
      .waddr (vec_addr),
      .wdata (cmd.wr_value),
      .raddr (vec_addr),
      .rdata (vec_rdata)
   );

   // Only the low 32 bits of each product matter, so signedness does not.
   assign prod_in  = mat_rdata * vec_rdata;
   assign acc_in   = s2_first_ff ? prod_ff : acc_ff + prod_ff;
   assign row_done = s2_valid_ff && s2_last_ff;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.err) begin
         rsp_data_in.result_value = '0;
         rsp_data_in.result_row   = '0;
         rsp_data_in.last         = 1'b1;
         rsp_data_in.status       = STATUS_OUT_RANGE;
         rsp_valid_in             = 1'b1;
      end else if (row_done) begin
         rsp_data_in.result_value = acc_in;
         rsp_data_in.result_row   = s2_row_ff;
         rsp_data_in.last         = s2_last_row_ff;
         rsp_data_in.status       = STATUS_OK;
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff    <= cmd.rd_first;
      s1_last_ff     <= cmd.rd_last;
      s1_last_row_ff <= cmd.rd_last_row;
      s1_row_ff      <= cmd.row;
      s2_first_ff    <= s1_first_ff;
      s2_last_ff     <= s1_last_ff;
      s2_last_row_ff <= s1_last_row_ff;
      s2_row_ff      <= s1_row_ff;
      prod_ff        <= prod_in;
      rsp_data_ff    <= rsp_data_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign status.busy     = rsp_valid_ff && rsp_stall;
   assign status.row_done = row_done;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   `IMVM_ASSERT_IMPL(a_no_overwrite, clock, reset, row_done, !(rsp_valid_ff && rsp_stall), "row result would overwrite a waiting item")
   `IMVM_ASSERT_IMPL(a_writes_when_quiet, clock, reset, cmd.mat_we || cmd.vec_we || cmd.err, !s1_valid_ff && !s2_valid_ff, "load handled while a multiply is in flight")
   `IMVM_ASSERT_NEXT(a_read_reaches_product, clock, reset, cmd.rd_en && cmd.rd_last, s1_valid_ff && s1_last_ff, "last column read lost in the pipeline")

endmodule

/* rtl/int_matrix_vector_multiply.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_data  (operation, row, column, value)
// rsp       out        rsp_valid/rsp_stall   rsp_data  (result value, row, last, status)
// csr       in         csr_we                csr_index, csr_wdata (num_rows, num_cols)
//
// Loads can be accepted back to back while no stalled result holds the block.
// A multiply does one matrix RAM read and one multiply per column of each row,
// then drains the product and accumulate stages before the next row starts.
// Reset is synchronous; both sizes return to 1 and the stores are undefined.
// A stalled result holds the block: no new row starts and no item is accepted
// until the output register is free.
module int_matrix_vector_multiply #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  imvm_pkg::req_data_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output imvm_pkg::rsp_data_type      rsp_data,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [imvm_pkg::CFG_W-1:0]  csr_wdata
);

   import imvm_pkg::*;

   cmd_type    cmd;
   status_type status;

   imvm_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   imvm_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
